[hdl/hms_pkg.sv]
// Package for the hh:mm:ss up/down kitchen timer.
// Holds command and mode codes, limits and the item structs; no dependencies.
package hms_pkg;

    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_START_STOP = 3'd1;
    localparam logic [2:0] CMD_LONG_PRESS = 3'd2;
    localparam logic [2:0] CMD_STOP_ALARM = 3'd3;
    localparam logic [2:0] CMD_SET_TIME   = 3'd4;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_ALARM = 2'd2;

    localparam logic [1:0] LEVEL_NONE    = 2'd0;
    localparam logic [1:0] LEVEL_SECONDS = 2'd1;
    localparam logic [1:0] LEVEL_MINUTES = 2'd2;
    localparam logic [1:0] LEVEL_HOURS   = 2'd3;

    localparam logic [4:0] MAX_SET_HOURS = 5'd19;
    localparam logic [6:0] MAX_SET_MS    = 7'd99;
    localparam logic [6:0] LAST_MS       = 7'd59;
    localparam logic [6:0] MS_PER_UNIT   = 7'd60;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] new_hours;
        logic [6:0] new_minutes;
        logic [6:0] new_seconds;
        logic       save_new;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] cur_hours;
        logic [6:0] cur_minutes;
        logic [6:0] cur_seconds;
        logic [1:0] run_state;
        logic       counting_down;
        logic [1:0] change_level;
        logic       alarm_started;
        logic       display_live;
        logic [7:0] lap_hours;
        logic [6:0] lap_minutes;
        logic [6:0] lap_seconds;
    } status_item_t;

    typedef struct packed {
        logic [7:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } hms_time_t;

endpackage

[hdl/hms_stream_if.sv]
// Valid/ready channel carrying one payload of type T per transaction.
// Used by the timer top level with the item structs of hms_pkg.
interface hms_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/hms_up_down_kitchen_timer.sv]
// Top level of the hh:mm:ss up/down kitchen timer with lap capture and alarm.
// Depends on hms_pkg and hms_stream_if.
//
//   channel    role   payload          meaning
//   cmd_ch     sink   cmd_item_t       tick, button command or new time
//   status_ch  source status_item_t    count, mode, flags and lap after the command
//
// One command per cycle while the status register is not stalled: a transaction lands
// in the input register, and when it advances the timer state is updated and the
// status register loaded. The status register stalls both stages while it waits;
// the input stage still takes a transaction whenever it is empty or moving on.
// Reset clears the count, preset, lap and the live and down flags and sets the fresh flag; the timer comes up stopped.
module hms_up_down_kitchen_timer (
    input  logic         clk,
    input  logic         rst_n,
    hms_stream_if.sink   cmd_ch,
    hms_stream_if.source status_ch
);
    import hms_pkg::*;

    cmd_item_t    item_reg;
    logic         item_valid_reg;
    status_item_t status_reg, status_next;
    logic         status_valid_reg;
    logic         advance;

    hms_time_t    count_reg, count_next;
    hms_time_t    preset_reg, preset_next;
    hms_time_t    lap_reg, lap_next;
    logic [1:0]   mode_reg, mode_next;
    logic         down_reg, down_next;
    logic         fresh_reg, fresh_next;
    logic         live_reg, live_next;
    logic [1:0]   level;
    logic         alarm;

    hms_time_t    new_time;
    hms_time_t    loaded;
    logic [6:0]   sec_inc;
    logic [6:0]   min_inc;

    // Status register drains or is empty: the item in flight can retire.
    assign advance = item_valid_reg && (!status_valid_reg || status_ch.ready);
    assign cmd_ch.ready = !item_valid_reg || advance;
    assign status_ch.valid = status_valid_reg;
    assign status_ch.data = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ch.ready)
                item_valid_reg <= cmd_ch.valid;
            if (advance)
                status_valid_reg <= 1'b1;
            else if (status_ch.ready)
                status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.ready && cmd_ch.valid)
            item_reg <= cmd_ch.data;
        if (advance)
            status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            preset_reg <= '0;
            lap_reg    <= '0;
            mode_reg   <= MODE_STOP;
            down_reg   <= 1'b0;
            fresh_reg  <= 1'b1;
            live_reg   <= 1'b0;
        end
        else if (advance)
        begin
            count_reg  <= count_next;
            preset_reg <= preset_next;
            lap_reg    <= lap_next;
            mode_reg   <= mode_next;
            down_reg   <= down_next;
            fresh_reg  <= fresh_next;
            live_reg   <= live_next;
        end
    end

    // Saturate the requested time before it becomes the preset.
    always_comb
    begin
        new_time.hours   = {3'd0, (item_reg.new_hours > MAX_SET_HOURS) ? MAX_SET_HOURS
                                                                     : item_reg.new_hours};
        new_time.minutes = (item_reg.new_minutes > MAX_SET_MS) ? MAX_SET_MS
                                                               : item_reg.new_minutes;
        new_time.seconds = (item_reg.new_seconds > MAX_SET_MS) ? MAX_SET_MS
                                                               : item_reg.new_seconds;
    end

    assign loaded  = item_reg.save_new ? new_time : preset_reg;
    assign sec_inc = count_reg.seconds + 7'd1;
    assign min_inc = count_reg.minutes + 7'd1;

    always_comb
    begin
        count_next  = count_reg;
        preset_next = preset_reg;
        lap_next    = lap_reg;
        mode_next   = mode_reg;
        down_next   = down_reg;
        fresh_next  = fresh_reg;
        live_next   = live_reg;
        level       = LEVEL_NONE;
        alarm       = 1'b0;

        unique case (item_reg.cmd)
            CMD_TICK:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    level = LEVEL_SECONDS;
                    if (down_reg)
                    begin
                        if (count_reg.seconds != 7'd0)
                            count_next.seconds = count_reg.seconds - 7'd1;
                        else if (count_reg.hours == 8'd0 && count_reg.minutes == 7'd0)
                        begin
                            // Expiry: raise the alarm and reload the preset.
                            mode_next  = MODE_ALARM;
                            count_next = preset_reg;
                            alarm      = 1'b1;
                            level      = LEVEL_HOURS;
                        end
                        else
                        begin
                            count_next.seconds = LAST_MS;
                            level = LEVEL_MINUTES;
                            if (count_reg.minutes != 7'd0)
                                count_next.minutes = count_reg.minutes - 7'd1;
                            else
                            begin
                                count_next.minutes = LAST_MS;
                                count_next.hours   = count_reg.hours - 8'd1;
                                level = LEVEL_HOURS;
                            end
                        end
                    end
                    else
                    begin
                        count_next.seconds = sec_inc;
                        if (sec_inc >= MS_PER_UNIT)
                        begin
                            count_next.seconds = 7'd0;
                            count_next.minutes = min_inc;
                            level = LEVEL_MINUTES;
                            if (min_inc >= MS_PER_UNIT)
                            begin
                                count_next.minutes = 7'd0;
                                count_next.hours   = count_reg.hours + 8'd1;
                                level = LEVEL_HOURS;
                            end
                        end
                    end
                end
            end
            CMD_START_STOP:
            begin
                live_next = 1'b1;
                if (mode_reg == MODE_STOP)
                begin
                    mode_next = MODE_RUN;
                    if (fresh_reg)
                        down_next = (count_reg != '0);
                end
                else
                begin
                    mode_next  = MODE_STOP;
                    fresh_next = 1'b0;
                end
            end
            CMD_LONG_PRESS:
            begin
                if (mode_reg == MODE_STOP)
                begin
                    preset_next = '0;
                    down_next   = 1'b0;
                end
                else if (mode_reg == MODE_RUN)
                begin
                    live_next = !live_reg;
                    lap_next  = count_reg;
                end
            end
            CMD_STOP_ALARM:
                mode_next = MODE_STOP;
            CMD_SET_TIME:
            begin
                live_next   = 1'b1;
                mode_next   = MODE_STOP;
                fresh_next  = 1'b1;
                preset_next = loaded;
                count_next  = loaded;
                down_next   = (loaded != '0);
            end
            default:
            begin
                // Unused command codes: hold everything.
            end
        endcase
    end

    always_comb
    begin
        status_next.cur_hours     = count_next.hours;
        status_next.cur_minutes   = count_next.minutes;
        status_next.cur_seconds   = count_next.seconds;
        status_next.run_state     = mode_next;
        status_next.counting_down = down_next;
        status_next.change_level  = level;
        status_next.alarm_started = alarm;
        status_next.display_live  = live_next;
        status_next.lap_hours     = lap_next.hours;
        status_next.lap_minutes   = lap_next.minutes;
        status_next.lap_seconds   = lap_next.seconds;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the hh:mm:ss up/down kitchen timer: directed and random commands.
// Checks every status transaction against an in-bench timer model.
// Depends on hms_pkg, hms_stream_if and hms_up_down_kitchen_timer.
module tb_top;
    import hms_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int PHASE_ITEMS     = 185;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic clk = 1'b0;
    logic rst_n;

    hms_stream_if #(.T(cmd_item_t))    cmd_ch ();
    hms_stream_if #(.T(status_item_t)) status_ch ();

    hms_up_down_kitchen_timer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .status_ch (status_ch)
    );

    always #5 clk = ~clk;

    cmd_item_t    pending_cmds[$];
    status_item_t expected_status[$];
    logic         cmd_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         hold_off_armed = 1'b0;
    int           hold_off_count = 0;
    int           mismatch_count = 0;
    int           queued_total = 0;
    int           quiet_cycles = 0;

    // Timer model state
    hms_time_t    timer_count = '0;
    hms_time_t    lap_time = '0;
    logic [4:0]   preset_hours = '0;
    logic [6:0]   preset_minutes = '0;
    logic [6:0]   preset_seconds = '0;
    logic [1:0]   timer_mode = MODE_STOP;
    logic         down_count = 1'b0;
    logic         fresh_set = 1'b1;
    logic         display_on = 1'b0;

    function automatic status_item_t apply_command(cmd_item_t c);
        logic [1:0]   level;
        logic         alarm;
        status_item_t res;
        level = LEVEL_NONE;
        alarm = 1'b0;
        case (c.cmd)
            CMD_TICK:
            begin
                if (timer_mode == MODE_RUN)
                begin
                    level = LEVEL_SECONDS;
                    if (down_count)
                    begin
                        if (timer_count.seconds != '0)
                            timer_count.seconds = timer_count.seconds - 7'd1;
                        else if (timer_count.hours == '0 && timer_count.minutes == '0)
                        begin
                            // expiry: alarm and reload the preset
                            timer_mode  = MODE_ALARM;
                            timer_count = {3'b000, preset_hours, preset_minutes, preset_seconds};
                            alarm       = 1'b1;
                            level       = LEVEL_HOURS;
                        end
                        else
                        begin
                            timer_count.seconds = LAST_MS;
                            level = LEVEL_MINUTES;
                            if (timer_count.minutes != '0)
                                timer_count.minutes = timer_count.minutes - 7'd1;
                            else
                            begin
                                timer_count.minutes = LAST_MS;
                                level = LEVEL_HOURS;
                                timer_count.hours = timer_count.hours - 8'd1;
                            end
                        end
                    end
                    else
                    begin
                        timer_count.seconds = timer_count.seconds + 7'd1;
                        if (timer_count.seconds >= MS_PER_UNIT)
                        begin
                            timer_count.seconds = '0;
                            level = LEVEL_MINUTES;
                            timer_count.minutes = timer_count.minutes + 7'd1;
                            if (timer_count.minutes >= MS_PER_UNIT)
                            begin
                                timer_count.minutes = '0;
                                level = LEVEL_HOURS;
                                timer_count.hours = timer_count.hours + 8'd1;
                            end
                        end
                    end
                end
            end
            CMD_START_STOP:
            begin
                display_on = 1'b1;
                if (timer_mode == MODE_STOP)
                begin
                    timer_mode = MODE_RUN;
                    if (fresh_set)
                        down_count = (timer_count != '0);
                end
                else
                begin
                    timer_mode = MODE_STOP;
                    fresh_set  = 1'b0;
                end
            end
            CMD_LONG_PRESS:
            begin
                if (timer_mode == MODE_STOP)
                begin
                    preset_hours   = '0;
                    preset_minutes = '0;
                    preset_seconds = '0;
                    down_count     = 1'b0;
                end
                else if (timer_mode == MODE_RUN)
                begin
                    display_on = ~display_on;
                    lap_time   = timer_count;
                end
            end
            CMD_STOP_ALARM:
                timer_mode = MODE_STOP;
            CMD_SET_TIME:
            begin
                display_on = 1'b1;
                timer_mode = MODE_STOP;
                fresh_set  = 1'b1;
                if (c.save_new)
                begin
                    preset_hours   = (c.new_hours > MAX_SET_HOURS) ? MAX_SET_HOURS : c.new_hours;
                    preset_minutes = (c.new_minutes > MAX_SET_MS) ? MAX_SET_MS : c.new_minutes;
                    preset_seconds = (c.new_seconds > MAX_SET_MS) ? MAX_SET_MS : c.new_seconds;
                end
                timer_count = {3'b000, preset_hours, preset_minutes, preset_seconds};
                down_count  = (timer_count != '0);
            end
            default:
            begin
            end
        endcase
        res.cur_hours     = timer_count.hours;
        res.cur_minutes   = timer_count.minutes;
        res.cur_seconds   = timer_count.seconds;
        res.run_state     = timer_mode;
        res.counting_down = down_count;
        res.change_level  = level;
        res.alarm_started = alarm;
        res.display_live  = display_on;
        res.lap_hours     = lap_time.hours;
        res.lap_minutes   = lap_time.minutes;
        res.lap_seconds   = lap_time.seconds;
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_status(status_item_t e, status_item_t a);
        check_field("cur_hours", e.cur_hours, a.cur_hours);
        check_field("cur_minutes", 8'(e.cur_minutes), 8'(a.cur_minutes));
        check_field("cur_seconds", 8'(e.cur_seconds), 8'(a.cur_seconds));
        check_field("run_state", 8'(e.run_state), 8'(a.run_state));
        check_field("counting_down", 8'(e.counting_down), 8'(a.counting_down));
        check_field("change_level", 8'(e.change_level), 8'(a.change_level));
        check_field("alarm_started", 8'(e.alarm_started), 8'(a.alarm_started));
        check_field("display_live", 8'(e.display_live), 8'(a.display_live));
        check_field("lap_hours", e.lap_hours, a.lap_hours);
        check_field("lap_minutes", 8'(e.lap_minutes), 8'(a.lap_minutes));
        check_field("lap_seconds", 8'(e.lap_seconds), 8'(a.lap_seconds));
    endtask

    function automatic cmd_item_t make_cmd(logic [2:0] code, logic [4:0] h, logic [6:0] m,
                                           logic [6:0] s, logic save);
        cmd_item_t item;
        item.cmd         = code;
        item.new_hours   = h;
        item.new_minutes = m;
        item.new_seconds = s;
        item.save_new    = save;
        return item;
    endfunction

    // Button or tick with random don't-care time fields
    function automatic cmd_item_t button(logic [2:0] code);
        return make_cmd(code, 5'($urandom_range(31)), 7'($urandom_range(127)),
                        7'($urandom_range(127)), 1'($urandom_range(1)));
    endfunction

    function automatic cmd_item_t random_item();
        int        pick;
        cmd_item_t item;
        item = button(CMD_TICK);
        pick = $urandom_range(99);
        if (pick < 50)
            item.cmd = CMD_TICK;
        else if (pick < 62)
            item.cmd = CMD_START_STOP;
        else if (pick < 72)
            item.cmd = CMD_LONG_PRESS;
        else if (pick < 78)
            item.cmd = CMD_STOP_ALARM;
        else if (pick < 94)
            item.cmd = CMD_SET_TIME;
        else
            item.cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        return item;
    endfunction

    task automatic queue_cmd(cmd_item_t item);
        pending_cmds.push_back(item);
        queued_total++;
    endtask

    // Ticks while running, with an occasional lap, pause or stray command
    task automatic queue_running_ticks(int ticks);
        int pick;
        repeat (ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                queue_cmd(button(CMD_LONG_PRESS));
            else if (pick < 9)
            begin
                queue_cmd(button(CMD_START_STOP));
                queue_cmd(button(CMD_START_STOP));
            end
            else if (pick < 10)
                queue_cmd(random_item());
            else
                queue_cmd(button(CMD_TICK));
        end
    endtask

    // Short countdown that usually runs out into the alarm
    task automatic queue_countdown_run();
        logic [6:0] mins;
        logic [6:0] secs;
        mins = ($urandom_range(3) == 0) ? 7'd1 : 7'd0;
        secs = 7'($urandom_range(20));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd0, mins, secs, 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_running_ticks(60 * int'(mins) + int'(secs) + $urandom_range(8, 1));
        queue_cmd(button($urandom_range(1) ? CMD_STOP_ALARM : CMD_START_STOP));
    endtask

    // Force an up count from a value near the hour so carries reach the hours
    task automatic queue_upcount_run();
        queue_cmd(make_cmd(CMD_SET_TIME, 5'($urandom_range(MAX_SET_HOURS)),
                           7'($urandom_range(99, 55)), 7'($urandom_range(99, 50)), 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_LONG_PRESS));
        queue_cmd(button(CMD_START_STOP));
        queue_running_ticks($urandom_range(70, 10));
        queue_cmd(button(CMD_START_STOP));
    endtask

    task automatic queue_random_phase(int budget);
        int stop_at;
        int pick;
        stop_at = queued_total + budget;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_countdown_run();
            else if (pick < 65)
                queue_upcount_run();
            else
                repeat ($urandom_range(6, 1)) queue_cmd(random_item());
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_status.size() != 0);
    endtask

    // Command driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_ch.data  <= pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Status receiver: random stalls plus one long hold-off when armed
    always @(negedge clk)
    begin
        if (!rst_n)
            status_ch.ready <= 1'b0;
        else if (hold_off_armed && hold_off_count < HOLD_OFF_CYCLES)
        begin
            status_ch.ready <= 1'b0;
            hold_off_count  <= hold_off_count + 1;
        end
        else
            status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check results first, then predict for the accepted command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status transaction with no command pending");
                    mismatch_count++;
                end
                else
                    compare_status(expected_status.pop_front(), status_ch.data);
            end
            if (cmd_ch.valid && cmd_ch.ready)
                expected_status.push_back(apply_command(cmd_ch.data));
        end
        cmd_taken <= rst_n && cmd_ch.valid && cmd_ch.ready;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, spare code, saturation, cancel, borrows, expiry, up carry
        queue_cmd(make_cmd(CMD_TICK, 5'd31, 7'd127, 7'd127, 1'b1));
        queue_cmd(make_cmd(CMD_SPARE_FIRST, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd31, 7'd127, 7'd127, 1'b1));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd0, 7'd0, 7'd0, 1'b0));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_TICK));
        queue_cmd(button(CMD_LONG_PRESS));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd0, 7'd1, 7'd0, 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_TICK));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd1, 7'd0, 7'd0, 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_TICK));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd0, 7'd0, 7'd1, 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_TICK));
        queue_cmd(button(CMD_TICK));
        queue_cmd(button(CMD_LONG_PRESS));
        queue_cmd(button(CMD_STOP_ALARM));
        queue_cmd(make_cmd(CMD_SET_TIME, 5'd0, 7'd99, 7'd99, 1'b1));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_LONG_PRESS));
        queue_cmd(button(CMD_START_STOP));
        queue_cmd(button(CMD_TICK));
        wait_drained();

        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 80;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 80;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        // Hold the receiver off while commands keep coming, so the pipe backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_armed = 1'b1;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
